// File: rtl/core/assert_macros.svh
// Assertion macros for the RTL files; included by rau_back.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define RAU_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Implication checked at every rising clock edge, reset included.
`define RAU_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// File: rtl/core/rau_pkg.sv
// Package for the rational arithmetic unit: widths, op codes, fraction type passed from front to back.
// No dependencies.
package rau_pkg;
	localparam int OperandWidth = 16;
	localparam int MagWidth = 2 * OperandWidth + 1;
	localparam int NumWidth = 33;
	localparam int DenWidth = 31;

	localparam logic [2:0] OP_REDUCE = 3'd0;
	localparam logic [2:0] OP_ADD = 3'd1;
	localparam logic [2:0] OP_SUB = 3'd2;
	localparam logic [2:0] OP_MUL = 3'd3;
	localparam logic [2:0] OP_DIV = 3'd4;

	// raw fraction in sign-magnitude form, handed from front to back
	typedef struct packed {
		logic num_neg;
		logic [MagWidth-1:0] num_mag;
		logic den_neg;
		logic [MagWidth-1:0] den_mag;
	} frac_t;
endpackage

// File: rtl/core/rau_front.sv
// Front end: accepts items, forms cross products in sign-magnitude form.
// Depends on rau_pkg.
module rau_front import rau_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [2:0] op,
	input  logic signed [OperandWidth-1:0] first_num,
	input  logic signed [OperandWidth-1:0] first_den,
	input  logic signed [OperandWidth-1:0] second_num,
	input  logic signed [OperandWidth-1:0] second_den,
	output logic out_valid,
	input  logic out_ready,
	output frac_t out_frac
);
	localparam int PW = 2 * OperandWidth;

	logic busy_s1;
	logic [2:0] op_s1;
	logic n1s_s1, d1s_s1, n2s_s1, d2s_s1;
	logic [PW-1:0] pa_s1, pb_s1, pd_s1;
	logic [OperandWidth-1:0] n1m, d1m, n2m, d2m;
	logic [OperandWidth-1:0] m0a, m0b, m1a, m1b, m2a, m2b;
	logic [PW-1:0] sa, sb;
	logic sa_neg, sb_neg;

	function automatic logic [OperandWidth-1:0] mag(input logic [OperandWidth-1:0] v);
		mag = v[OperandWidth-1] ? (~v + 1'b1) : v;
	endfunction

	assign n1m = mag(first_num);
	assign d1m = mag(first_den);
	assign n2m = mag(second_num);
	assign d2m = mag(second_den);

	// three multipliers: products depend on op
	always_comb begin
		m0a = n1m; m0b = d2m;
		m1a = n2m; m1b = d1m;
		m2a = d1m; m2b = d2m;
		case (op)
			OP_MUL: begin m0a = n1m; m0b = n2m; end
			OP_DIV: begin m2a = d1m; m2b = n2m; end
			OP_REDUCE: begin m0b = OperandWidth'(1); m2b = OperandWidth'(1); end
			default: ;
		endcase
	end

	assign in_ready = !busy_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
		end else if (in_ready) begin
			busy_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1 <= op;
			n1s_s1 <= first_num[OperandWidth-1];
			d1s_s1 <= first_den[OperandWidth-1];
			n2s_s1 <= second_num[OperandWidth-1];
			d2s_s1 <= second_den[OperandWidth-1];
			pa_s1 <= PW'(m0a) * PW'(m0b);
			pb_s1 <= PW'(m1a) * PW'(m1b);
			pd_s1 <= PW'(m2a) * PW'(m2b);
		end
	end

	// second stage logic: signs and add/sub of the numerator products
	always_comb begin
		sa_neg = (pa_s1 != '0) && (n1s_s1 != d2s_s1);
		sb_neg = (pb_s1 != '0) && (n2s_s1 != d1s_s1);
		if (op_s1 == OP_SUB && pb_s1 != '0) sb_neg = !sb_neg;
		sa = pa_s1;
		sb = pb_s1;
	end

	always_comb begin
		out_frac = '0;
		unique case (op_s1)
			OP_ADD, OP_SUB: begin
				if (sa_neg == sb_neg) begin
					out_frac.num_neg = sa_neg;
					out_frac.num_mag = MagWidth'(sa) + MagWidth'(sb);
				end else if (sa >= sb) begin
					out_frac.num_neg = sa_neg;
					out_frac.num_mag = MagWidth'(sa - sb);
				end else begin
					out_frac.num_neg = sb_neg;
					out_frac.num_mag = MagWidth'(sb - sa);
				end
				out_frac.den_mag = MagWidth'(pd_s1);
				out_frac.den_neg = d1s_s1 != d2s_s1;
			end
			OP_MUL: begin
				out_frac.num_mag = MagWidth'(pa_s1);
				out_frac.num_neg = n1s_s1 != n2s_s1;
				out_frac.den_mag = MagWidth'(pd_s1);
				out_frac.den_neg = d1s_s1 != d2s_s1;
			end
			OP_DIV: begin
				out_frac.num_mag = MagWidth'(pa_s1);
				out_frac.num_neg = n1s_s1 != d2s_s1;
				out_frac.den_mag = MagWidth'(pd_s1);
				out_frac.den_neg = d1s_s1 != n2s_s1;
			end
			default: begin
				// reduce: first fraction passed through the unit multipliers
				out_frac.num_mag = MagWidth'(pa_s1);
				out_frac.num_neg = n1s_s1;
				out_frac.den_mag = MagWidth'(pd_s1);
				out_frac.den_neg = d1s_s1;
			end
		endcase
	end

	assign out_valid = busy_s1;
endmodule

// File: rtl/core/rau_back.sv
// Back end: Euclidean GCD and the two divisions by the GCD, one bit per cycle.
// Depends on rau_pkg.
module rau_back import rau_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  frac_t in_frac,
	output logic empty,
	input  logic pop,
	output logic signed [NumWidth-1:0] result_num,
	output logic [DenWidth-1:0] result_den,
	output logic div_zero
);
	`include "assert_macros.svh"

	localparam int MW = MagWidth;
	localparam int CW = $clog2(MW + 1);

	typedef enum logic [2:0] {
		ST_IDLE, ST_GCD, ST_DIVN, ST_DIVD, ST_DONE
	} state_t;

	state_t state_q;
	logic neg_q;
	logic [MW-1:0] b_q, nm_q, dm_q, quo_q, rem_q, dvd_q, g_q;
	logic [CW-1:0] cnt_q;
	logic gcd_div_q;
	logic [MW:0] trial;
	logic [MW-1:0] rsh;
	logic out_full_q;

	// restoring divider: shift dividend bit into remainder, try subtract
	assign rsh = {rem_q[MW-2:0], dvd_q[MW-1]};
	assign trial = {1'b0, rsh} - {1'b0, (gcd_div_q ? b_q : g_q)};
	assign in_ready = (state_q == ST_IDLE);
	assign empty = !out_full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_full_q <= 1'b0;
			gcd_div_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (pop && out_full_q) out_full_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						neg_q <= in_frac.num_neg != in_frac.den_neg;
						nm_q <= in_frac.num_mag;
						dm_q <= in_frac.den_mag;
						if (in_frac.den_mag == '0 || in_frac.num_mag == '0) begin
							state_q <= ST_DONE;
						end else begin
							b_q <= in_frac.den_mag;
							dvd_q <= in_frac.num_mag;
							rem_q <= '0;
							cnt_q <= CW'(MW);
							gcd_div_q <= 1'b1;
							state_q <= ST_GCD;
						end
					end
				end
				ST_GCD: begin
					// one a % b per pass, one bit a cycle
					if (trial[MW]) rem_q <= rsh;
					else rem_q <= trial[MW-1:0];
					dvd_q <= {dvd_q[MW-2:0], 1'b0};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CW'(1)) begin
						if ((trial[MW] ? rsh : trial[MW-1:0]) == '0) begin
							g_q <= b_q;
							gcd_div_q <= 1'b0;
							dvd_q <= nm_q;
							rem_q <= '0;
							cnt_q <= CW'(MW);
							state_q <= ST_DIVN;
						end else begin
							b_q <= trial[MW] ? rsh : trial[MW-1:0];
							dvd_q <= b_q;
							rem_q <= '0;
							cnt_q <= CW'(MW);
						end
					end
				end
				ST_DIVN, ST_DIVD: begin
					if (trial[MW]) rem_q <= rsh;
					else rem_q <= trial[MW-1:0];
					dvd_q <= {dvd_q[MW-2:0], 1'b0};
					quo_q <= {quo_q[MW-2:0], !trial[MW]};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CW'(1)) begin
						rem_q <= '0;
						cnt_q <= CW'(MW);
						if (state_q == ST_DIVN) begin
							nm_q <= {quo_q[MW-2:0], !trial[MW]};
							dvd_q <= dm_q;
							state_q <= ST_DIVD;
						end else begin
							dm_q <= {quo_q[MW-2:0], !trial[MW]};
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (!out_full_q || pop) begin
						out_full_q <= 1'b1;
						div_zero <= (dm_q == '0);
						if (dm_q == '0) begin
							result_num <= '0;
							result_den <= '0;
						end else if (nm_q == '0) begin
							result_num <= '0;
							result_den <= DenWidth'(1);
						end else begin
							result_num <= neg_q ? NumWidth'(-nm_q) : NumWidth'(nm_q);
							result_den <= DenWidth'(dm_q);
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`RAU_ASSERT(a_ready_idle, clk, arst_n, in_ready |-> state_q == ST_IDLE, "ready outside idle")
	`RAU_ASSERT(a_count, clk, arst_n, (state_q == ST_GCD) |-> cnt_q != '0, "bit count ran out")
	`RAU_ASSERT(a_den_pos, clk, arst_n, (!empty && !div_zero) |-> result_den != '0, "zero den without flag")
endmodule

// File: rtl/core/rational_arithmetic_unit_top.sv
// Top level of the rational arithmetic unit.
// Depends on rau_pkg, rau_front, rau_back.
//
// channel  | handshake        | ports
// input    | push / full      | op, first_num, first_den, second_num, second_den
// result   | empty / pop      | result_num, result_den, div_zero
//
// The front end multiplies as it accepts an item and holds one item in its output stage.
// The back end runs Euclid's GCD with a bit-serial remainder unit, then two
// bit-serial divisions by the GCD; it takes no new item until its result is
// stored, and its run time is set by the number of remainder steps.
// Reset (arst_n low) empties both stages; the front stage holds while the back works.
module rational_arithmetic_unit_top import rau_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  logic [2:0] op,
	input  logic signed [OperandWidth-1:0] first_num,
	input  logic signed [OperandWidth-1:0] first_den,
	input  logic signed [OperandWidth-1:0] second_num,
	input  logic signed [OperandWidth-1:0] second_den,
	output logic empty,
	input  logic pop,
	output logic signed [NumWidth-1:0] result_num,
	output logic [DenWidth-1:0] result_den,
	output logic div_zero
);
	logic in_ready, mid_valid, mid_ready;
	frac_t mid_frac;
	logic [2:0] op_eff;

	// unused codes act as reduce
	assign op_eff = (op > OP_DIV) ? OP_REDUCE : op;
	assign full = !in_ready;

	rau_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(push), .in_ready(in_ready),
		.op(op_eff),
		.first_num(first_num), .first_den(first_den),
		.second_num(second_num), .second_den(second_den),
		.out_valid(mid_valid), .out_ready(mid_ready), .out_frac(mid_frac)
	);

	rau_back u_back (
		.clk(clk), .arst_n(arst_n),
		.in_valid(mid_valid), .in_ready(mid_ready), .in_frac(mid_frac),
		.empty(empty), .pop(pop),
		.result_num(result_num), .result_den(result_den), .div_zero(div_zero)
	);
endmodule
